// ===== design/seb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sonar echo peak binner package
// Item types, field codes and constants shared by the binner design.
// ----------------------------------------------------------------------------
package seb_pkg;

  // Default number of range bins.
  localparam int unsigned NUM_BINS_DEF = 512;

  // Echo conditioning: converter reading is shifted down to 8 bits and
  // clamped below the two reserved codes.
  localparam int unsigned ADC_SHIFT = 4;
  localparam logic [7:0]  ECHO_MAX  = 8'd253;

  // Item mode codes.
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NOISE_THR = 2'd0;
  localparam logic [1:0] CFG_SPB       = 2'd1;
  localparam logic [1:0] CFG_RANGE     = 2'd2;

  // Input item.
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] sample;
    logic [8:0]  read_index;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] read_value;
    logic       busy_res;
    logic       done_res;
  } out_item_t;

endpackage

// ===== design/sonar_echo_peak_binner_top.sv =====
// A result passes through the read stage register and then the output register.
// Throughput: one item per cycle unless the output stalls; the bin memory
// read-modify-write spans the read and write stages, forwarding pending writes.
// Reset clears control state only. The bin memory is not initialized; a fill
// count marks the bins written since the last start, so no clearing pass runs.
// ----------------------------------------------------------------------------
// Sonar echo peak binner
// Captures the peak echo strength of each range bin during a ping and serves
// bin reads, keeping the bins in one synchronous memory.
// ----------------------------------------------------------------------------
module sonar_echo_peak_binner_top #(
  parameter int unsigned NUM_BINS = seb_pkg::NUM_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  seb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output seb_pkg::out_item_t out_item_o
);
  import seb_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BINS);
  localparam int unsigned FILL_W = IDX_W + 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

  // Configuration registers.
  logic [7:0] noise_thr_q, spb_q, range_code_q;

  // Capture control state.
  logic [IDX_W-1:0]  bin_idx_q, bin_idx_d;
  logic [7:0]        cnt_q, cnt_d;
  logic              capt_q, capt_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovr_q, ovr_d;
  logic [7:0]        ovr_code_q, ovr_code_d;

  // Read stage registers.
  logic             s1_valid_q;
  logic             s1_is_smp_q, s1_is_smp_d;
  logic             s1_use_mem_q, s1_use_mem_d;
  logic [7:0]       s1_const_q, s1_const_d;
  logic [7:0]       s1_echo_q, s1_echo_d;
  logic [IDX_W-1:0] s1_addr_q, s1_addr_d;
  logic             s1_busy_q, s1_done_q;
  logic             fwd_hit_q, fwd_hit_d;
  logic [7:0]       fwd_data_q;

  // Bin memory.
  logic [7:0] bin_mem_q [NUM_BINS];
  logic [7:0] mem_rd_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_item_q;

  logic             accept, s1_adv, mem_we;
  logic [7:0]       rd_data, wr_data, echo_raw;
  logic [CMP_W-1:0] ridx_ext;
  logic [IDX_W-1:0] ridx_addr;
  logic             ridx_ok, ridx_valid, cur_valid;

  // Handshakes: the read stage moves on whenever the output register frees.
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_thr_q  <= 8'd0;
      spb_q        <= 8'd1;
      range_code_q <= 8'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NOISE_THR: noise_thr_q  <= cfg_data_i;
        CFG_SPB:       spb_q        <= cfg_data_i;
        CFG_RANGE:     range_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Echo conditioning: shift, clamp, then noise gate.
  always_comb begin
    echo_raw = in_item_i.sample[ADC_SHIFT +: 8];
    if (echo_raw > ECHO_MAX) begin
      echo_raw = ECHO_MAX;
    end
    if (echo_raw < noise_thr_q) begin
      s1_echo_d = 8'd0;
    end else begin
      s1_echo_d = echo_raw;
    end
  end

  // Read index decode; bins below the fill count were written since start.
  assign ridx_ext   = CMP_W'(in_item_i.read_index);
  assign ridx_ok    = ridx_ext < CMP_W'(NUM_BINS);
  assign ridx_addr  = ridx_ext[IDX_W-1:0];
  assign ridx_valid = ridx_ok && (FILL_W'(ridx_addr) < fill_q);
  assign cur_valid  = FILL_W'(bin_idx_q) < fill_q;

  // Control update and read issue for the accepted item.
  always_comb begin
    bin_idx_d    = bin_idx_q;
    cnt_d        = cnt_q;
    capt_d       = capt_q;
    fill_d       = fill_q;
    ovr_d        = ovr_q;
    ovr_code_d   = ovr_code_q;
    s1_is_smp_d  = 1'b0;
    s1_use_mem_d = 1'b0;
    s1_const_d   = 8'd0;
    s1_addr_d    = bin_idx_q;
    unique case (in_item_i.mode)
      MODE_START: begin
        bin_idx_d = '0;
        cnt_d     = spb_q;
        capt_d    = 1'b1;
        fill_d    = '0;
        ovr_d     = 1'b0;
      end
      MODE_SAMPLE: begin
        if (capt_q) begin
          s1_is_smp_d  = 1'b1;
          s1_use_mem_d = cur_valid;
          fill_d       = FILL_W'(bin_idx_q) + FILL_W'(1);
          cnt_d        = cnt_q - 8'd1;
          if (cnt_d == 8'd0) begin
            cnt_d = spb_q;
            if (bin_idx_q == IDX_W'(NUM_BINS - 1)) begin
              // Last bin done: bin 0 now reads as the latched range code.
              bin_idx_d  = '0;
              capt_d     = 1'b0;
              ovr_d      = 1'b1;
              ovr_code_d = range_code_q;
            end else begin
              bin_idx_d = bin_idx_q + IDX_W'(1);
            end
          end
        end
      end
      MODE_READ: begin
        s1_addr_d = ridx_addr;
        if (ovr_q && ridx_ok && (ridx_addr == '0)) begin
          s1_const_d = ovr_code_q;
        end else begin
          s1_use_mem_d = ridx_valid;
        end
      end
      default: ;
    endcase
  end

  // Write stage: peak update of the bin read by the read stage.
  assign rd_data = s1_use_mem_q ? (fwd_hit_q ? fwd_data_q : mem_rd_q) : s1_const_q;
  assign wr_data = (s1_echo_q > rd_data) ? s1_echo_q : rd_data;
  assign mem_we  = s1_adv && s1_is_smp_q;
  assign fwd_hit_d = mem_we && (s1_addr_q == s1_addr_d);

  // Bin memory with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem_q[s1_addr_q] <= wr_data;
    end
    if (accept) begin
      mem_rd_q <= bin_mem_q[s1_addr_d];
    end
  end

  // Control state and read stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_idx_q  <= '0;
      cnt_q      <= 8'd0;
      capt_q     <= 1'b0;
      fill_q     <= '0;
      ovr_q      <= 1'b0;
      ovr_code_q <= 8'd0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        bin_idx_q  <= bin_idx_d;
        cnt_q      <= cnt_d;
        capt_q     <= capt_d;
        fill_q     <= fill_d;
        ovr_q      <= ovr_d;
        ovr_code_q <= ovr_code_d;
        fwd_hit_q  <= fwd_hit_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_is_smp_q  <= s1_is_smp_d;
      s1_use_mem_q <= s1_use_mem_d;
      s1_const_q   <= s1_const_d;
      s1_echo_q    <= s1_echo_d;
      s1_addr_q    <= s1_addr_d;
      s1_busy_q    <= capt_d;
      s1_done_q    <= s1_is_smp_d && capt_q && !capt_d;
      fwd_data_q   <= wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q.read_value <= s1_is_smp_q ? 8'd0 : rd_data;
      out_item_q.busy_res   <= s1_busy_q;
      out_item_q.done_res   <= s1_done_q;
    end
  end

endmodule
